>>> rtl/lru_key_value_cache_top_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Property helpers for the file that carries concurrent checks.
// They expect signals named clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LKVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LKVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic load;    // latch the accepted request
    logic lookup;  // compare tags, pick slots
    logic commit;  // update entries, load the result register
  } lkvc_cmd_t;

endpackage

>>> rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
//
// Request channel (in_valid/in_ready): kind (0 get, 1 put), lookup_key and
// write_value. Result channel (out_valid/out_ready): hit, read_value and
// evicted, one result for every request, in order.
// Configuration channel (cfg_valid/cfg_ready): cfg_data, ready whenever
// reset is low; write it only while no request is in flight. Values are
// clamped to 1..16.
// Requests are handled one at a time: the accepted request is latched, the
// lookup state compares the tags and picks the slots, and the commit state
// updates the entries and loads the result register, raising out_valid. A
// new request is taken only after the previous one has committed.
// A stalled receiver holds the result register; the next request is still
// taken and looked up, and its commit waits until the result register frees.
// Reset clears all valid bits, recency ranks and the fill count, and sets
// the capacity to 16. in_ready is low in reset and is set after its release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top
  import lkvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data
);

  lkvc_cmd_t cmd;

  assign cfg_ready = !rst;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted)
  );

  `LKVC_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")
  `LKVC_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid, "commit did not present a result")
  `LKVC_ASSERT_IMP(a_miss_zero, out_valid && !hit, read_value == '0, "miss returned nonzero")
  `LKVC_ASSERT_IMP(a_evict_miss, out_valid && evicted, !hit, "eviction flagged on a hit")

endmodule

>>> rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences accept, lookup and commit, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lkvc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !out_valid || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.lookup = (state == ST_LOOKUP);
  assign cmd.commit = (state == ST_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_LOOKUP;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          // hold until the result register can take the new result
          if (out_free) begin
            in_ready <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry storage, parallel tag compare, recency ranks and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_datapath
  import lkvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lkvc_cmd_t               cmd,
  input  logic                    cfg_wr,
  input  logic [CAP_W-1:0]        cfg_data,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted
);

  logic signed [KEY_W-1:0] entry_keys   [ENTRIES];
  logic signed [VAL_W-1:0] entry_values [ENTRIES];
  logic [ENTRIES-1:0]      entry_valid;
  logic [IDX_W-1:0]        entry_age    [ENTRIES];
  logic [COUNT_W-1:0]      used_count;
  logic [CAP_W-1:0]        capacity;

  // latched request
  logic                    req_put;
  logic signed [KEY_W-1:0] req_key;
  logic signed [VAL_W-1:0] req_val;

  // lookup results
  logic             hit_q;
  logic             full_q;
  logic             old_found_q;
  logic [IDX_W-1:0] hit_slot_q;
  logic [IDX_W-1:0] free_slot_q;
  logic [IDX_W-1:0] old_slot_q;

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] old_vec;
  logic [IDX_W-1:0]   hit_slot;
  logic [IDX_W-1:0]   free_slot;
  logic [IDX_W-1:0]   old_slot;
  logic [COUNT_W-1:0] cap_eff;

  logic             do_touch;
  logic             do_fill;
  logic             do_evict;
  logic [IDX_W-1:0] touch_slot;
  logic [IDX_W-1:0] touch_age;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap_eff = COUNT_W'(ENTRIES);
    end else begin
      cap_eff = COUNT_W'(capacity);
    end
  end

  // Ranks of valid entries form 0..used_count-1, so the oldest one holds the top rank.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_keys[i] == req_key);
      old_vec[i]   = entry_valid[i] &&
                     (COUNT_W'(entry_age[i]) == used_count - COUNT_W'(1));
    end
  end

  // lowest index wins
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    old_slot  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_slot = IDX_W'(i);
      if (!entry_valid[i]) free_slot = IDX_W'(i);
      if (old_vec[i]) old_slot = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put <= kind;
      req_key <= lookup_key;
      req_val <= write_value;
    end
    if (cmd.lookup) begin
      hit_q       <= |match_vec;
      full_q      <= (used_count >= cap_eff);
      old_found_q <= |old_vec;
      hit_slot_q  <= hit_slot;
      free_slot_q <= free_slot;
      old_slot_q  <= old_slot;
    end
  end

  assign do_touch   = hit_q || do_evict;
  assign do_fill    = !hit_q && (req_put == KIND_PUT) && !full_q;
  assign do_evict   = !hit_q && (req_put == KIND_PUT) && full_q && old_found_q;
  assign touch_slot = hit_q ? hit_slot_q : old_slot_q;
  assign touch_age  = entry_age[touch_slot];

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_fill) begin
        entry_keys[free_slot_q]   <= req_key;
        entry_values[free_slot_q] <= req_val;
      end else if (do_evict) begin
        entry_keys[old_slot_q]   <= req_key;
        entry_values[old_slot_q] <= req_val;
      end else if (hit_q && (req_put == KIND_PUT)) begin
        entry_values[hit_slot_q] <= req_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      used_count  <= '0;
      capacity    <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      if (cmd.commit) begin
        if (do_touch) begin
          // age the entries more recent than the touched one
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i] && (IDX_W'(i) != touch_slot) &&
                (entry_age[i] < touch_age)) begin
              entry_age[i] <= entry_age[i] + IDX_W'(1);
            end
          end
          entry_age[touch_slot] <= '0;
        end else if (do_fill) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i]) begin
              entry_age[i] <= entry_age[i] + IDX_W'(1);
            end
          end
          entry_valid[free_slot_q] <= 1'b1;
          entry_age[free_slot_q]   <= '0;
          used_count               <= used_count + COUNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit     <= hit_q;
      evicted <= do_evict;
      if (hit_q && (req_put == KIND_GET)) begin
        read_value <= entry_values[hit_slot_q];
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put requests into the cache and checks every result against
// a row's expected result or a cycle-free LRU model kept in the bench. A
// short table of directed requests covers the key and value extremes, both
// operations, lowering the capacity below the fill and clamping it at both
// ends. Random phases then run at several capacity settings and flow-control
// mixes, with a long result stall and a drain of all outstanding results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int PRESSURE_PH  = 4;
  localparam int LONG_HOLD    = 300;
  localparam int POOL_MAX     = 24;

  localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] data;
    logic             displaced;
  } lookup_result_t;

  localparam lookup_result_t NO_HIT  = '{1'b0, 32'h0, 1'b0};
  localparam lookup_result_t EVICTED = '{1'b0, 32'h0, 1'b1};

  typedef struct {
    bit               set_cap;
    logic [CAP_W-1:0] cap;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               typed;
    lookup_result_t   want;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = KIND_GET;
  logic signed [KEY_W-1:0] lookup_key = '0;
  logic signed [VAL_W-1:0] write_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data = CAP_RESET;

  // model of the cache contents
  logic [KEY_W-1:0] slot_key [ENTRIES];
  logic [VAL_W-1:0] slot_val [ENTRIES];
  bit               slot_live [ENTRIES];
  int               slot_rank [ENTRIES];
  int               live_count = 0;
  logic [CAP_W-1:0] cap_setting = CAP_RESET;

  lookup_result_t awaited_results [$];
  lookup_result_t oldest;
  directed_row_t  dir_rows [$];

  int          errors = 0;
  int          sent_count = 0;
  int          hits_seen = 0;
  int          evictions_seen = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int unsigned cycle_count;

  lru_key_value_cache_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int effective_capacity();
    int c;
    c = cap_setting;
    if (c < 1) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  // Make slot s the most recent; live entries younger than it age by one.
  function automatic void promote_slot(input int s);
    int old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic lookup_result_t cache_access(input logic op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
    lookup_result_t r;
    int slot;
    r = NO_HIT;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && slot_live[i] && slot_key[i] == key) slot = i;
    if (slot >= 0) begin
      r.found = 1'b1;
      if (op == KIND_PUT) slot_val[slot] = val;
      else r.data = slot_val[slot];
      promote_slot(slot);
    end else if (op == KIND_PUT) begin
      if (live_count < effective_capacity()) begin
        // lowest free slot takes the new entry, all others age
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!slot_live[i]) slot = i;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_rank[i]++;
        slot_live[slot] = 1'b1;
        slot_key[slot]  = key;
        slot_val[slot]  = val;
        slot_rank[slot] = 0;
        live_count++;
      end else begin
        // replace the oldest live entry; the lowest index wins a tie
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        if (slot >= 0) begin
          r.displaced   = 1'b1;
          slot_key[slot] = key;
          slot_val[slot] = val;
          promote_slot(slot);
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val, input bit typed,
                              input lookup_result_t want);
    lookup_result_t predicted;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    kind        <= op;
    lookup_key  <= key;
    write_value <= val;
    do @(posedge clk); while (!in_ready);
    predicted = cache_access(op, key, val);
    hits_seen      += predicted.found;
    evictions_seen += predicted.displaced;
    awaited_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Drop valid and hold until every outstanding result has transferred.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cap_setting = cap;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // receiver: random stalls, plus a long hold when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got hit=%0b read_value=%h evicted=%0b",
                 $time, hit, read_value, evicted);
        errors++;
      end else begin
        oldest = awaited_results.pop_front();
        check_field("hit", 32'(oldest.found), 32'(hit));
        check_field("read_value", oldest.data, read_value);
        check_field("evicted", 32'(oldest.displaced), 32'(evicted));
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap  [PHASES];
    int               phase_send [PHASES];
    int               phase_recv [PHASES];
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int               pool_n;
    logic             op;
    logic [KEY_W-1:0] key;

    phase_cap  = '{5'd6, 5'd2, 5'd31, 5'd1, 5'd16, 5'd0, 5'd12, 5'd16};
    phase_send = '{0, 62, 0, 19, 0, 62, 0, 19};
    phase_recv = '{0, 0, 62, 19, 0, 0, 62, 19};

    // reset capacity: empty cache, extremes of key and value
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, 32'h0, 32'h0, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_PUT, KEY_MIN, KEY_MAX, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_PUT, KEY_MAX, KEY_MIN, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, KEY_MIN, 32'h0, 1'b1,
                                       lookup_result_t'{1'b1, KEY_MAX, 1'b0}});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, KEY_MAX, ALL_ONES, 1'b1,
                                       lookup_result_t'{1'b1, KEY_MIN, 1'b0}});
    // put hit overwrites and reads back zero
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_PUT, KEY_MAX, 32'h0, 1'b1,
                                       lookup_result_t'{1'b1, 32'h0, 1'b0}});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, ALL_ONES, 32'h0, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_PUT, ALL_ONES, ALL_ONES, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, ALL_ONES, 32'h0, 1'b1,
                                       lookup_result_t'{1'b1, ALL_ONES, 1'b0}});
    // capacity lowered below the fill: put misses replace the oldest entry
    dir_rows.push_back(directed_row_t'{1'b1, 5'd1, KIND_PUT, 32'd5, 32'd55, 1'b1, EVICTED});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, KEY_MIN, 32'h0, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_PUT, 32'd6, 32'd66, 1'b1, EVICTED});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, 32'd5, 32'h0, 1'b0, NO_HIT});
    // zero clamps up to one
    dir_rows.push_back(directed_row_t'{1'b1, 5'd0, KIND_PUT, 32'd7, 32'd77, 1'b1, EVICTED});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, 32'd6, 32'h0, 1'b0, NO_HIT});
    // above the entry count clamps down, free slots remain
    dir_rows.push_back(directed_row_t'{1'b1, 5'd31, KIND_PUT, 32'd8, 32'd88, 1'b1, NO_HIT});
    dir_rows.push_back(directed_row_t'{1'b0, 5'd0, KIND_GET, 32'd7, 32'h0, 1'b0, NO_HIT});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].set_cap) begin
        drain();
        write_capacity(dir_rows[n].cap);
      end
      send_request(dir_rows[n].op, dir_rows[n].key, dir_rows[n].val,
                   dir_rows[n].typed, dir_rows[n].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_capacity(phase_cap[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // a key pool a little larger than the capacity gives hits and evictions
      pool_n = effective_capacity() + $urandom_range(0, 6);
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PRESSURE_PH && n == 20) hold_request = LONG_HOLD;
        if (p == PRESSURE_PH && n == 120) drain();
        op = ($urandom_range(99) < 45) ? KIND_PUT : KIND_GET;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_n - 1)];
        else key = $urandom;
        send_request(op, key, $urandom, 1'b0, NO_HIT);
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (%0d directed) over capacities 0 to 31 and four handshake mixes",
             sent_count, dir_rows.size());
    $display("Model saw %0d hits and %0d evictions", hits_seen, evictions_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_top.sv
test/tb.sv
